// ----- rtl/area_method_time_constant_estimator_macros.svh -----
// assertion macros used by the estimator back end
`ifndef AREA_METHOD_TIME_CONSTANT_ESTIMATOR_MACROS_SVH
`define AREA_METHOD_TIME_CONSTANT_ESTIMATOR_MACROS_SVH

// same-cycle implication, off during reset
`define AMTE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define AMTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/amte_pkg.sv -----
// shared types and constants of the time constant estimator
`timescale 1ns / 1ps
`default_nettype none

package amte_pkg;

  localparam int unsigned AMTE_FIFO_DEPTH = 4;
  localparam logic signed [31:0] FINAL_VALUE_RESET = 32'sd65536;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FEW    = 2'd1,
    STATUS_ZERO   = 2'd2,
    STATUS_NONPOS = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [31:0] sample_value;
    logic               last_sample;
  } in_t;

  typedef struct packed {
    logic signed [31:0] time_constant;
    status_e            status;
  } out_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic [31:0] half_sum;
    logic [31:0] step;
    logic        odd;
    logic        neg;
    logic        has_interval;
    logic        last;
    logic        few;
  } op_t;

endpackage

`default_nettype wire

// ----- rtl/amte_front.sv -----
// front end: takes samples, forms shortfall sum and time step per interval
`timescale 1ns / 1ps
`default_nettype none

module amte_front
  import amte_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic signed [31:0] final_value_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_t                in_i,
  output logic                    op_valid_o,
  input  wire logic               op_ready_i,
  output op_t                     op_o
);

  localparam logic [1:0] SEEN_MAX = 2'd2;

  logic [31:0]        prev_time_q, prev_time_d;
  logic signed [31:0] prev_value_q, prev_value_d;
  logic [1:0]         seen_q, seen_d;

  logic               accept;
  logic [32:0]        err_prev, err_cur;
  logic [31:0]        sf_prev, sf_cur;
  logic [32:0]        sum;
  logic               later;

  assign in_ready_o = op_ready_i;
  assign op_valid_o = in_valid_i;
  assign accept     = in_valid_i & op_ready_i;

  always_comb begin
    err_prev = {final_value_i[31], final_value_i} - {prev_value_q[31], prev_value_q};
    err_cur  = {final_value_i[31], final_value_i} - {in_i.sample_value[31], in_i.sample_value};
    sf_prev  = err_prev[32] ? 32'd0 : err_prev[31:0];
    sf_cur   = err_cur[32] ? 32'd0 : err_cur[31:0];
    sum      = {1'b0, sf_prev} + {1'b0, sf_cur};
    later    = in_i.sample_time >= prev_time_q;

    op_o.half_sum     = sum[32:1];
    op_o.odd          = sum[0];
    op_o.step         = later ? (in_i.sample_time - prev_time_q)
                              : (prev_time_q - in_i.sample_time);
    op_o.neg          = ~later;
    op_o.has_interval = seen_q != 2'd0;
    op_o.last         = in_i.last_sample;
    op_o.few          = in_i.last_sample & (seen_q == 2'd0);
  end

  always_comb begin
    prev_time_d  = prev_time_q;
    prev_value_d = prev_value_q;
    seen_d       = seen_q;
    if (accept) begin
      if (in_i.last_sample) begin
        prev_time_d  = '0;
        prev_value_d = '0;
        seen_d       = '0;
      end else begin
        prev_time_d  = in_i.sample_time;
        prev_value_d = in_i.sample_value;
        seen_d       = (seen_q == SEEN_MAX) ? SEEN_MAX : seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q  <= '0;
      prev_value_q <= '0;
      seen_q       <= '0;
    end else begin
      prev_time_q  <= prev_time_d;
      prev_value_q <= prev_value_d;
      seen_q       <= seen_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/amte_fifo.sv -----
// short queue of classified samples between front and back
`timescale 1ns / 1ps
`default_nettype none

module amte_fifo
  import amte_pkg::*;
#(
  parameter int unsigned DEPTH = AMTE_FIFO_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire op_t  push_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output op_t       pop_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  op_t           mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  assign push_ready_o = count_q != CW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/amte_back.sv -----
// back end: interval area, saturating accumulation, final division and result
`timescale 1ns / 1ps
`default_nettype none

`include "area_method_time_constant_estimator_macros.svh"

module amte_back
  import amte_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic signed [31:0] final_value_i,
  input  wire logic               op_valid_i,
  output logic                    op_ready_o,
  input  wire op_t                op_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_t                    out_o
);

  typedef enum logic [1:0] {
    TAIL_IDLE,
    TAIL_DIV,
    TAIL_FIN,
    TAIL_OUT
  } tail_e;

  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic signed [63:0] AREA_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] AREA_MIN = {1'b1, {63{1'b0}}};

  logic               pop;

  // product stage
  logic               p1_valid_q;
  logic [63:0]        prod_q;
  logic [30:0]        half_q;
  logic               p1_neg_q, p1_has_q, p1_last_q, p1_few_q;
  logic [63:0]        prod;

  // magnitude stage
  logic               p2_valid_q;
  logic [63:0]        mag_q;
  logic               p2_neg_q, p2_has_q, p2_last_q, p2_few_q;

  logic signed [63:0] area_q;
  logic [65:0]        ext, mext, acc;
  logic signed [63:0] acc_sat, new_area;
  logic [63:0]        area_mag;
  logic [31:0]        fv_mag;

  tail_e              state_q;
  logic [CNT_W-1:0]   div_cnt_q;
  logic [63:0]        div_num_q;
  logic [31:0]        div_rem_q;
  logic [31:0]        div_den_q;
  logic               div_neg_q;
  out_t               out_q;

  logic [32:0]        trial;
  logic               fits;
  logic [31:0]        rem_next;
  logic signed [31:0] tau;

  logic               tail_end;
  logic               ok_out;
  logic               div_mid;

  assign op_ready_o  = (state_q == TAIL_IDLE) & ~(p1_valid_q & p1_last_q)
                     & ~(p2_valid_q & p2_last_q);
  assign pop         = op_valid_i & op_ready_o;
  assign prod        = {32'd0, op_i.half_sum} * {32'd0, op_i.step};
  assign out_valid_o = state_q == TAIL_OUT;
  assign out_o       = out_q;

  assign tail_end = p2_valid_q & p2_last_q;
  assign ok_out   = out_valid_o & (out_q.status == STATUS_OK);
  assign div_mid  = (state_q == TAIL_DIV) & (div_cnt_q != DIV_LAST);

  always_comb begin
    ext      = {{2{area_q[63]}}, area_q};
    mext     = {2'b00, mag_q};
    acc      = p2_neg_q ? (ext - mext) : (ext + mext);
    if (acc[65:63] == 3'b000 || acc[65:63] == 3'b111) begin
      acc_sat = acc[63:0];
    end else if (acc[65]) begin
      acc_sat = AREA_MIN;
    end else begin
      acc_sat = AREA_MAX;
    end
    new_area = p2_has_q ? acc_sat : area_q;
    area_mag = new_area[63] ? (64'd0 - new_area) : new_area;
    fv_mag   = final_value_i[31] ? (32'd0 - final_value_i) : final_value_i;
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {div_rem_q, div_num_q[63]};
    fits     = trial >= {1'b0, div_den_q};
    rem_next = fits ? 32'(trial - {1'b0, div_den_q}) : trial[31:0];
  end

  always_comb begin
    if (div_neg_q) begin
      tau = (div_num_q > 64'h0000_0000_8000_0000) ? 32'sh8000_0000
                                                  : 32'd0 - div_num_q[31:0];
    end else begin
      tau = (div_num_q > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                  : div_num_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= pop;
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      prod_q    <= prod;
      half_q    <= op_i.odd ? op_i.step[31:1] : 31'd0;
      p1_neg_q  <= op_i.neg;
      p1_has_q  <= op_i.has_interval;
      p1_last_q <= op_i.last;
      p1_few_q  <= op_i.few;
    end
    if (p1_valid_q) begin
      mag_q     <= prod_q + {33'd0, half_q};
      p2_neg_q  <= p1_neg_q;
      p2_has_q  <= p1_has_q;
      p2_last_q <= p1_last_q;
      p2_few_q  <= p1_few_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q <= '0;
    end else if (p2_valid_q) begin
      area_q <= p2_last_q ? 64'sd0 : new_area;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= TAIL_IDLE;
      div_cnt_q <= '0;
      div_num_q <= '0;
      div_rem_q <= '0;
      div_den_q <= '0;
      div_neg_q <= 1'b0;
      out_q     <= '{time_constant: '0, status: STATUS_OK};
    end else begin
      case (state_q)
        TAIL_IDLE: begin
          if (p2_valid_q && p2_last_q) begin
            if (p2_few_q) begin
              out_q   <= '{time_constant: '0, status: STATUS_FEW};
              state_q <= TAIL_OUT;
            end else if (final_value_i == 32'sd0) begin
              out_q   <= '{time_constant: '0, status: STATUS_ZERO};
              state_q <= TAIL_OUT;
            end else begin
              div_num_q <= area_mag;
              div_den_q <= fv_mag;
              div_rem_q <= '0;
              div_neg_q <= new_area[63] ^ final_value_i[31];
              div_cnt_q <= '0;
              state_q   <= TAIL_DIV;
            end
          end
        end
        TAIL_DIV: begin
          div_rem_q <= rem_next;
          div_num_q <= {div_num_q[62:0], fits};
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == DIV_LAST) begin
            state_q <= TAIL_FIN;
          end
        end
        TAIL_FIN: begin
          out_q.time_constant <= tau;
          out_q.status        <= (tau > 32'sd0) ? STATUS_OK : STATUS_NONPOS;
          state_q             <= TAIL_OUT;
        end
        TAIL_OUT: begin
          if (out_ready_i) begin
            state_q <= TAIL_IDLE;
          end
        end
        default: begin
          state_q <= TAIL_IDLE;
        end
      endcase
    end
  end

  `AMTE_ASSERT_IMPL(a_no_pop_in_tail, state_q != TAIL_IDLE, !pop, "sample taken while tail busy")
  `AMTE_ASSERT_IMPL(a_last_finds_idle, tail_end, state_q == TAIL_IDLE, "tail busy at record end")
  `AMTE_ASSERT_IMPL(a_ok_is_positive, ok_out, out_q.time_constant > 0, "non-positive ok result")
  `AMTE_ASSERT_NEXT(a_div_runs_on, div_mid, state_q == TAIL_DIV, "division left early")

endmodule

`default_nettype wire

// ----- rtl/area_method_time_constant_estimator.sv -----
// top level of the area method time constant estimator
// one sample is taken per cycle while the queue has room; a sample that ends no record adds a 3-stage area update
// a record end passes the area stages, then a 64-step divider and TAIL_FIN, to its result
// too few samples or a zero final value skip the divider and give their result directly
// while a result is pending the back stalls, the front keeps filling its queue
// async reset clears record state, queue and result, and sets final value to 1.0
`timescale 1ns / 1ps
`default_nettype none

module area_method_time_constant_estimator
  import amte_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = AMTE_FIFO_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic signed [31:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_t                in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_t                    out_o
);

  logic signed [31:0] final_value_q;
  logic               f_valid, f_ready;
  op_t                f_op;
  logic               b_valid, b_ready;
  op_t                b_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      final_value_q <= FINAL_VALUE_RESET;
    end else if (cfg_we_i) begin
      final_value_q <= cfg_wdata_i;
    end
  end

  amte_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .final_value_i (final_value_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_i          (in_i),
    .op_valid_o    (f_valid),
    .op_ready_i    (f_ready),
    .op_o          (f_op)
  );

  amte_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_i       (f_op),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_o        (b_op)
  );

  amte_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .final_value_i (final_value_q),
    .op_valid_i    (b_valid),
    .op_ready_o    (b_ready),
    .op_i          (b_op),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_o         (out_o)
  );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench: record stimulus, bit-exact time constant prediction, result scoreboard
module tb;
  import amte_pkg::*;

  localparam int ITEMS_PER_PHASE = 190;
  localparam int SETTLE_CYCLES = 100;
  localparam logic signed [65:0] AREA_MAX = 66'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [65:0] AREA_MIN = -66'sh8000_0000_0000_0000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic signed [31:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;

  logic signed [31:0] final_value_q = FINAL_VALUE_RESET;
  logic [31:0]        prev_time_q = '0;
  logic signed [31:0] prev_value_q = '0;
  logic signed [63:0] area_q = '0;
  logic [1:0]         seen_q = '0;

  in_t  pending_samples[$];
  out_t expected_results[$];
  out_t want_result;
  int   error_count = 0;
  int   pushed = 0;
  int   send_idle_pct = 30;
  int   recv_idle_pct = 67;

  area_method_time_constant_estimator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] shortfall(input logic signed [31:0] fv,
                                            input logic signed [31:0] y);
    logic [32:0] e;
    e = {fv[31], fv} - {y[31], y};
    return e[32] ? 32'd0 : e[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  task automatic estimate_sample(input in_t s);
    logic [32:0]        s_sum;
    logic [31:0]        d;
    logic [63:0]        mag;
    logic [63:0]        am;
    logic [63:0]        km;
    logic [63:0]        qm;
    logic signed [65:0] acc;
    logic signed [31:0] tau;
    status_e            st;
    out_t               r;
    if (seen_q != 2'd0) begin
      s_sum = {1'b0, shortfall(final_value_q, prev_value_q)}
            + {1'b0, shortfall(final_value_q, s.sample_value)};
      d = (s.sample_time >= prev_time_q) ? s.sample_time - prev_time_q
                                         : prev_time_q - s.sample_time;
      mag = {32'd0, s_sum[32:1]} * {32'd0, d};
      if (s_sum[0]) mag = mag + {33'd0, d[31:1]};
      acc = $signed({{2{area_q[63]}}, area_q});
      if (s.sample_time < prev_time_q) acc = acc - $signed({2'b00, mag});
      else acc = acc + $signed({2'b00, mag});
      if (acc > AREA_MAX) acc = AREA_MAX;
      else if (acc < AREA_MIN) acc = AREA_MIN;
      area_q = acc[63:0];
    end
    prev_time_q = s.sample_time;
    prev_value_q = s.sample_value;
    if (seen_q < 2'd2) seen_q = seen_q + 2'd1;
    if (s.last_sample) begin
      tau = '0;
      if (seen_q < 2'd2) begin
        st = STATUS_FEW;
      end else if (final_value_q == 32'sd0) begin
        st = STATUS_ZERO;
      end else begin
        am = area_q[63] ? 64'd0 - $unsigned(area_q) : $unsigned(area_q);
        km = final_value_q[31] ? 64'd0 - {{32{final_value_q[31]}}, final_value_q}
                               : {32'd0, final_value_q};
        qm = am / km;
        if (area_q[63] != final_value_q[31]) begin
          tau = (qm > 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - qm[31:0];
        end else begin
          tau = (qm > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qm[31:0];
        end
        st = (tau > 32'sd0) ? STATUS_OK : STATUS_NONPOS;
      end
      r.time_constant = tau;
      r.status = st;
      expected_results.push_back(r);
      prev_time_q = '0;
      prev_value_q = '0;
      area_q = '0;
      seen_q = '0;
    end
  endtask

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) estimate_sample(in_data);
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: time_constant %0d status %0d",
                 out_data.time_constant, out_data.status);
          error_count++;
        end else begin
          want_result = expected_results.pop_front();
          if (out_data.time_constant !== want_result.time_constant) begin
            $error("time_constant expected %0d actual %0d",
                   want_result.time_constant, out_data.time_constant);
            error_count++;
          end
          if (out_data.status !== want_result.status) begin
            $error("status expected %0d actual %0d", want_result.status, out_data.status);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_sample(input logic [31:0] t, input logic signed [31:0] y,
                             input logic last);
    in_t s;
    s.sample_time = t;
    s.sample_value = y;
    s.last_sample = last;
    pending_samples.push_back(s);
    pushed++;
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_final_value(input logic signed [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    final_value_q = v;
  endtask

  task automatic random_record();
    int          kind;
    int          n;
    int          y0;
    logic [31:0] t;
    longint      amp;
    longint      v;
    logic signed [31:0] y;
    kind = $urandom_range(99);
    if (kind < 70) begin
      // settling response toward the final value
      n = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 2);
      t = $urandom_range(1) ? 32'd0 : $urandom;
      y0 = $urandom_range(1) ? int'($urandom) : 0;
      amp = longint'(final_value_q) - longint'(y0);
      for (int k = 0; k < n; k++) begin
        v = longint'(final_value_q) - (amp >>> k) + longint'($urandom_range(64)) - 64'sd32;
        push_sample(t, sat32(v), k == n - 1);
        case ($urandom_range(9))
          0: t = t + $urandom;
          1: t = t - $urandom_range(255);
          default: t = t + $urandom_range(32'h0002_0000, 1);
        endcase
      end
    end else if (kind < 85) begin
      n = $urandom_range(5, 1);
      for (int k = 0; k < n; k++) push_sample($urandom, $urandom, k == n - 1);
    end else if (kind < 95) begin
      if ($urandom_range(1)) begin
        push_sample($urandom, $urandom, 1'b1);
      end else begin
        // time running backward
        n = $urandom_range(5, 2);
        t = $urandom;
        for (int k = 0; k < n; k++) begin
          push_sample(t, $urandom, k == n - 1);
          t = t - $urandom_range(32'h0010_0000);
        end
      end
    end else begin
      n = $urandom_range(4, 2);
      for (int k = 0; k < n; k++) begin
        t = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
        case ($urandom_range(3))
          0: y = 32'h8000_0000;
          1: y = 32'h7FFF_FFFF;
          2: y = 32'sd0;
          default: y = final_value_q;
        endcase
        push_sample(t, y, k == n - 1);
      end
    end
  endtask

  initial begin
    logic signed [31:0] phase_fv [10];
    int target;
    phase_fv = '{32'sd65536, 32'h7FFF_FFFF, 32'sd0, 32'h8000_0000, 32'sd0,
                 -32'sd65536, 32'sd1, 32'h0100_0000, 32'sd0, 32'hFFFF_FFFF};
    phase_fv[4] = $urandom;
    phase_fv[8] = $urandom;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // single sample record
    push_sample(32'd0, 32'sd0, 1'b1);
    // unit area
    push_sample(32'd0, 32'sd0, 1'b0);
    push_sample(32'h0001_0000, 32'sd0, 1'b1);
    // decreasing time
    push_sample(32'h0001_0000, 32'sd0, 1'b0);
    push_sample(32'd0, 32'sd0, 1'b1);
    // response above the final value, zero area
    push_sample(32'd0, 32'h7FFF_FFFF, 1'b0);
    push_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    // saturating area then a large backward step
    push_sample(32'd0, 32'h8000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    push_sample(32'd0, 32'sd0, 1'b0);
    push_sample(32'h0010_0000, 32'sh0000_8000, 1'b1);
    // odd shortfall sum
    push_sample(32'd0, 32'sd1, 1'b0);
    push_sample(32'd3, 32'sd0, 1'b1);
    // longer record
    push_sample(32'd0, 32'sd0, 1'b0);
    push_sample(32'd100, 32'sd30000, 1'b0);
    push_sample(32'd200, 32'sd50000, 1'b0);
    push_sample(32'd300, 32'sd60000, 1'b1);
    drain();

    for (int p = 0; p < 10; p++) begin
      set_final_value(phase_fv[p]);
      if (p < 4) begin
        send_idle_pct = 30;
        recv_idle_pct = 67;
      end else if (p < 7) begin
        send_idle_pct = 67;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      target = pushed + ITEMS_PER_PHASE;
      while (pushed < target) random_record();
      drain();
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
